FILE: hw/rtl/ggm_pkg.sv
// Shared constants, types and functions for the GGM tree key derivation block.
`default_nettype none
package ggm_pkg;

    localparam int MaxDepth = 32;
    localparam int LvlW     = 6;
    localparam int RndW     = 6;

    typedef logic [31:0] t_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // take a fresh key from the input ports
        logic init;      // start a compression on the current key
        logic round;     // perform one compression round
        logic finish;    // add the initial values and keep one half
        logic keep_left; // keep digest bytes 0..15
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_round;
    } t_dp_sts;

    function automatic t_word sha_k(input logic [RndW-1:0] i);
        t_word k;
        case (i)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    localparam t_word [7:0] ShaInit = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

endpackage
`default_nettype wire

FILE: hw/rtl/ggm_datapath.sv
// Datapath: key register, message schedule window and SHA-256 round unit.
`default_nettype none
module ggm_datapath (
    input  wire logic             i_clk,
    input  wire ggm_pkg::t_dp_cmd i_cmd,
    output ggm_pkg::t_dp_sts      o_sts,
    input  wire logic [63:0]      i_key_hi,
    input  wire logic [63:0]      i_key_lo,
    output logic [63:0]           o_key_hi,
    output logic [63:0]           o_key_lo
);

    logic [63:0] r_hi, r_lo;
    ggm_pkg::t_word r_w [16];
    ggm_pkg::t_word r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;
    logic [ggm_pkg::RndW-1:0] r_rnd;

    ggm_pkg::t_word s0, s1, n_w, t1, t2, bs0, bs1, ch, mj;
    ggm_pkg::t_word h0, h1, h2, h3, h4, h5, h6, h7;

    // Schedule: next word from the sliding sixteen-word window.
    always_comb begin
        s0  = {r_w[1][6:0], r_w[1][31:7]} ^ {r_w[1][17:0], r_w[1][31:18]} ^ (r_w[1] >> 3);
        s1  = {r_w[14][16:0], r_w[14][31:17]} ^ {r_w[14][18:0], r_w[14][31:19]}
            ^ (r_w[14] >> 10);
        n_w = r_w[0] + s0 + r_w[9] + s1;
    end

    // One compression round.
    always_comb begin
        bs1 = {r_e[5:0], r_e[31:6]} ^ {r_e[10:0], r_e[31:11]} ^ {r_e[24:0], r_e[31:25]};
        ch  = (r_e & r_f) ^ (~r_e & r_g);
        t1  = r_h + bs1 + ch + ggm_pkg::sha_k(r_rnd) + r_w[0];
        bs0 = {r_a[1:0], r_a[31:2]} ^ {r_a[12:0], r_a[31:13]} ^ {r_a[21:0], r_a[31:22]};
        mj  = (r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c);
        t2  = bs0 + mj;
    end

    // Final digest words.
    always_comb begin
        h0 = ggm_pkg::ShaInit[0] + r_a; h1 = ggm_pkg::ShaInit[1] + r_b;
        h2 = ggm_pkg::ShaInit[2] + r_c; h3 = ggm_pkg::ShaInit[3] + r_d;
        h4 = ggm_pkg::ShaInit[4] + r_e; h5 = ggm_pkg::ShaInit[5] + r_f;
        h6 = ggm_pkg::ShaInit[6] + r_g; h7 = ggm_pkg::ShaInit[7] + r_h;
    end

    // Registers of the datapath.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hi <= i_key_hi;
            r_lo <= i_key_lo;
        end else if (i_cmd.finish) begin
            if (i_cmd.keep_left) begin
                r_hi <= {h0, h1};
                r_lo <= {h2, h3};
            end else begin
                r_hi <= {h4, h5};
                r_lo <= {h6, h7};
            end
        end
        if (i_cmd.init) begin
            r_w[0] <= r_hi[63:32]; r_w[1] <= r_hi[31:0];
            r_w[2] <= r_lo[63:32]; r_w[3] <= r_lo[31:0];
            r_w[4] <= 32'h8000_0000;
            for (int i = 5; i < 15; i++) r_w[i] <= '0;
            r_w[15] <= 32'd128;
            r_a <= ggm_pkg::ShaInit[0]; r_b <= ggm_pkg::ShaInit[1];
            r_c <= ggm_pkg::ShaInit[2]; r_d <= ggm_pkg::ShaInit[3];
            r_e <= ggm_pkg::ShaInit[4]; r_f <= ggm_pkg::ShaInit[5];
            r_g <= ggm_pkg::ShaInit[6]; r_h <= ggm_pkg::ShaInit[7];
            r_rnd <= '0;
        end else if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= n_w;
            r_h <= r_g; r_g <= r_f; r_f <= r_e; r_e <= r_d + t1;
            r_d <= r_c; r_c <= r_b; r_b <= r_a; r_a <= t1 + t2;
            r_rnd <= r_rnd + 1'b1;
        end
    end

    assign o_sts.last_round = (r_rnd == '1);
    assign o_key_hi = r_hi;
    assign o_key_lo = r_lo;

endmodule
`default_nettype wire

FILE: hw/rtl/ggm_ctrl.sv
// Controller: walks the levels and sequences the compressions.
`default_nettype none
module ggm_ctrl (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [31:0]               i_leaf_offset,
    input  wire logic [ggm_pkg::LvlW-1:0]  i_from_level,
    input  wire logic [ggm_pkg::LvlW-1:0]  i_to_level,
    input  wire ggm_pkg::t_dp_sts          i_sts,
    output ggm_pkg::t_dp_cmd               o_cmd,
    output logic                           o_busy,
    output logic                           o_valid
);

    typedef enum logic [1:0] {S_IDLE, S_INIT, S_ROUND, S_FINISH} t_state;

    t_state r_state;
    logic [ggm_pkg::LvlW-1:0] r_lvl, r_to;
    logic [31:0] r_off;
    logic r_valid;
    logic [ggm_pkg::LvlW-1:0] from_sat;
    logic [ggm_pkg::LvlW-1:0] bitpos;
    logic accept;

    assign accept   = i_start && (r_state == S_IDLE);
    assign from_sat = (i_from_level > ggm_pkg::LvlW'(ggm_pkg::MaxDepth))
                    ? ggm_pkg::LvlW'(ggm_pkg::MaxDepth) : i_from_level;
    assign bitpos   = r_lvl - 1'b1;

    // Commands follow the state directly.
    always_comb begin
        o_cmd.load      = accept;
        o_cmd.init      = (r_state == S_INIT);
        o_cmd.round     = (r_state == S_ROUND);
        o_cmd.finish    = (r_state == S_FINISH);
        o_cmd.keep_left = (bitpos < 6'd32) && r_off[bitpos[4:0]];
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_lvl <= from_sat;
                        r_to  <= i_to_level;
                        r_off <= i_leaf_offset;
                        if (from_sat > i_to_level) r_state <= S_INIT;
                        else r_valid <= 1'b1;
                    end
                end
                S_INIT:  r_state <= S_ROUND;
                S_ROUND: if (i_sts.last_round) r_state <= S_FINISH;
                S_FINISH: begin
                    r_lvl <= r_lvl - 1'b1;
                    if (r_lvl - 1'b1 > r_to) r_state <= S_INIT;
                    else begin
                        r_state <= S_IDLE;
                        r_valid <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

    // A result is strobed only while the controller is idle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_state == S_IDLE) else $error("result strobe while busy");
    // A level loop ends strictly after the target level.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FINISH |-> r_lvl > r_to) else $error("level overran target");
    // Finishing follows the last round.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FINISH |-> $past(r_state) == S_ROUND) else $error("bad finish");

endmodule
`default_nettype wire

FILE: hw/rtl/ggm_tree_key_derive.sv
// Top level of the GGM tree key derivation block.
// Channel  | Handshake        | Payload
// input    | i_start, o_busy  | i_key_hi, i_key_lo, i_leaf_offset, i_from_level, i_to_level
// result   | o_valid (strobe) | o_out_key_hi, o_out_key_lo
// Each level runs init, 64 rounds of the shared round unit, and finish.
// An item walks the levels from i_from_level (capped at 32) down to i_to_level; at most 32.
// For a pass-through item o_valid follows in the cycle after i_start.
// Synchronous active-low reset returns the controller to idle.
// The result is shown for one cycle; the receiver cannot stall.
`default_nettype none
module ggm_tree_key_derive (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [63:0] i_key_hi,
    input  wire logic [63:0] i_key_lo,
    input  wire logic [31:0] i_leaf_offset,
    input  wire logic [5:0]  i_from_level,
    input  wire logic [5:0]  i_to_level,
    output logic             o_valid,
    output logic [63:0]      o_out_key_hi,
    output logic [63:0]      o_out_key_lo
);

    ggm_pkg::t_dp_cmd cmd;
    ggm_pkg::t_dp_sts sts;

    ggm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start),
        .i_leaf_offset(i_leaf_offset), .i_from_level(i_from_level),
        .i_to_level(i_to_level), .i_sts(sts), .o_cmd(cmd),
        .o_busy(o_busy), .o_valid(o_valid)
    );

    ggm_datapath u_dp (
        .i_clk(i_clk), .i_cmd(cmd), .o_sts(sts),
        .i_key_hi(i_key_hi), .i_key_lo(i_key_lo),
        .o_key_hi(o_out_key_hi), .o_key_lo(o_out_key_lo)
    );

endmodule
`default_nettype wire
